### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/nec_irtx_pkg.sv
`timescale 1ns / 1ps

package nec_irtx_pkg;

    localparam int PAYLOAD_WIDTH_DEF = 32;
    localparam int TIMER_WIDTH_DEF   = 16;
    localparam int PAYLOAD_IN_WIDTH  = 32;
    localparam int BIT_COUNT_WIDTH   = 6;
    localparam int CFG_WIDTH         = 16;
    localparam int CFG_INDEX_WIDTH   = 3;

    localparam logic [CFG_WIDTH-1:0] RST_CARRIER_HALF = 16'd13;
    localparam logic [CFG_WIDTH-1:0] RST_LEAD_MARK    = 16'd9000;
    localparam logic [CFG_WIDTH-1:0] RST_LEAD_SPACE   = 16'd4500;
    localparam logic [CFG_WIDTH-1:0] RST_BIT_MARK     = 16'd562;
    localparam logic [CFG_WIDTH-1:0] RST_ZERO_SPACE   = 16'd562;
    localparam logic [CFG_WIDTH-1:0] RST_ONE_SPACE    = 16'd1687;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD_MARK,
        PH_LEAD_SPACE,
        PH_BIT_MARK,
        PH_BIT_SPACE,
        PH_STOP_MARK,
        PH_STOP_SPACE
    } phase_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_CARRIER_HALF = 3'd0,
        REG_LEAD_MARK    = 3'd1,
        REG_LEAD_SPACE   = 3'd2,
        REG_BIT_MARK     = 3'd3,
        REG_ZERO_SPACE   = 3'd4,
        REG_ONE_SPACE    = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] carrier_half;
        logic [CFG_WIDTH-1:0] lead_mark;
        logic [CFG_WIDTH-1:0] lead_space;
        logic [CFG_WIDTH-1:0] bit_mark;
        logic [CFG_WIDTH-1:0] zero_space;
        logic [CFG_WIDTH-1:0] one_space;
    } cfg_t;

    typedef struct packed {
        logic ir_level;
        logic busy;
        logic done;
    } result_t;

endpackage

### hw/rtl/nec_irtx_cfg.sv
`timescale 1ns / 1ps

module nec_irtx_cfg
    import nec_irtx_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]       cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes to indexes past the last register fall through and change nothing.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_CARRIER_HALF: cfg_next.carrier_half = cfg_data;
                REG_LEAD_MARK:    cfg_next.lead_mark    = cfg_data;
                REG_LEAD_SPACE:   cfg_next.lead_space   = cfg_data;
                REG_BIT_MARK:     cfg_next.bit_mark     = cfg_data;
                REG_ZERO_SPACE:   cfg_next.zero_space   = cfg_data;
                REG_ONE_SPACE:    cfg_next.one_space    = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.carrier_half <= RST_CARRIER_HALF;
            cfg_reg.lead_mark    <= RST_LEAD_MARK;
            cfg_reg.lead_space   <= RST_LEAD_SPACE;
            cfg_reg.bit_mark     <= RST_BIT_MARK;
            cfg_reg.zero_space   <= RST_ZERO_SPACE;
            cfg_reg.one_space    <= RST_ONE_SPACE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/nec_irtx_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nec_irtx_core
    import nec_irtx_pkg::*;
#(
    parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF,
    parameter int TIMER_WIDTH   = TIMER_WIDTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic                        start_req,
    input  logic [PAYLOAD_IN_WIDTH-1:0] payload,
    input  logic [BIT_COUNT_WIDTH-1:0]  bit_count,
    input  cfg_t                        cfg,
    output result_t                     result
);

    localparam int BL_W = $clog2(PAYLOAD_WIDTH + 1);

    // A duration of zero after truncation to the timer width counts as one tick.
    function automatic logic [TIMER_WIDTH-1:0] dur(input logic [CFG_WIDTH-1:0] v);
        logic [TIMER_WIDTH-1:0] t;
        t = TIMER_WIDTH'(v);
        return (t == '0) ? TIMER_WIDTH'(1) : t;
    endfunction

    phase_t                   phase_reg, phase_next;
    logic [TIMER_WIDTH-1:0]   phase_timer_reg, phase_timer_next;
    logic [TIMER_WIDTH-1:0]   carrier_timer_reg, carrier_timer_next;
    logic                     carrier_level_reg, carrier_level_next;
    logic [PAYLOAD_WIDTH-1:0] shift_reg, shift_next;
    logic [BL_W-1:0]          bits_left_reg, bits_left_next;

    logic                     start_frame;
    logic                     active;
    phase_t                   cur_phase;
    logic [TIMER_WIDTH-1:0]   cur_pt;
    logic [TIMER_WIDTH-1:0]   cur_ct;
    logic                     cur_cl;
    logic [PAYLOAD_WIDTH-1:0] cur_shift;
    logic [BL_W-1:0]          cur_bl;
    logic [BL_W-1:0]          bl_dec;
    logic [BL_W-1:0]          bl_load;
    logic                     is_mark;
    logic                     pt_end;
    logic                     ct_end;

    // A start tick is already the first tick of the frame, so the frame's
    // initial values stand in for the idle state on that tick.
    assign start_frame = (phase_reg == PH_IDLE) && start_req;
    assign active      = (phase_reg != PH_IDLE) || start_req;
    assign bl_load     = (32'(bit_count) > 32'(PAYLOAD_WIDTH)) ? BL_W'(PAYLOAD_WIDTH)
                                                               : BL_W'(bit_count);

    assign cur_phase = start_frame ? PH_LEAD_MARK        : phase_reg;
    assign cur_pt    = start_frame ? dur(cfg.lead_mark)  : phase_timer_reg;
    assign cur_ct    = start_frame ? dur(cfg.carrier_half) : carrier_timer_reg;
    assign cur_cl    = start_frame ? 1'b1                : carrier_level_reg;
    assign cur_shift = start_frame ? PAYLOAD_WIDTH'(payload) : shift_reg;
    assign cur_bl    = start_frame ? bl_load             : bits_left_reg;

    assign bl_dec  = cur_bl - BL_W'(1);
    assign is_mark = (cur_phase == PH_LEAD_MARK) || (cur_phase == PH_BIT_MARK)
                  || (cur_phase == PH_STOP_MARK);
    assign pt_end  = (cur_pt == TIMER_WIDTH'(1));
    assign ct_end  = (cur_ct == TIMER_WIDTH'(1));

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (accept && active)
        begin
            phase_next = cur_phase;
            if (pt_end)
            begin
                unique case (cur_phase)
                    PH_LEAD_MARK:  phase_next = PH_LEAD_SPACE;
                    PH_LEAD_SPACE: phase_next = (cur_bl != '0) ? PH_BIT_MARK : PH_STOP_MARK;
                    PH_BIT_MARK:   phase_next = PH_BIT_SPACE;
                    PH_BIT_SPACE:  phase_next = (bl_dec != '0) ? PH_BIT_MARK : PH_STOP_MARK;
                    PH_STOP_MARK:  phase_next = PH_STOP_SPACE;
                    default:       phase_next = PH_IDLE;
                endcase
            end
        end
    end

    // Timers, carrier and payload shifter.
    always_comb
    begin
        phase_timer_next   = phase_timer_reg;
        carrier_timer_next = carrier_timer_reg;
        carrier_level_next = carrier_level_reg;
        shift_next         = shift_reg;
        bits_left_next     = bits_left_reg;
        if (accept && active)
        begin
            phase_timer_next   = cur_pt - TIMER_WIDTH'(1);
            carrier_timer_next = cur_ct;
            carrier_level_next = cur_cl;
            shift_next         = cur_shift;
            bits_left_next     = cur_bl;
            if (is_mark)
            begin
                carrier_timer_next = cur_ct - TIMER_WIDTH'(1);
                if (ct_end)
                begin
                    carrier_level_next = ~cur_cl;
                    carrier_timer_next = dur(cfg.carrier_half);
                end
            end
            if (pt_end)
            begin
                case (cur_phase)
                    PH_LEAD_MARK:
                    begin
                        phase_timer_next   = dur(cfg.lead_space);
                        carrier_level_next = 1'b0;
                    end
                    PH_LEAD_SPACE:
                    begin
                        phase_timer_next   = dur(cfg.bit_mark);
                        carrier_timer_next = dur(cfg.carrier_half);
                        carrier_level_next = 1'b1;
                    end
                    PH_BIT_MARK:
                    begin
                        phase_timer_next   = cur_shift[0] ? dur(cfg.one_space)
                                                          : dur(cfg.zero_space);
                        carrier_level_next = 1'b0;
                    end
                    PH_BIT_SPACE:
                    begin
                        shift_next         = cur_shift >> 1;
                        bits_left_next     = bl_dec;
                        phase_timer_next   = dur(cfg.bit_mark);
                        carrier_timer_next = dur(cfg.carrier_half);
                        carrier_level_next = 1'b1;
                    end
                    PH_STOP_MARK:
                    begin
                        phase_timer_next   = dur(cfg.zero_space);
                        carrier_level_next = 1'b0;
                    end
                    default:
                    begin
                        phase_timer_next   = '0;
                        carrier_timer_next = '0;
                        carrier_level_next = 1'b0;
                    end
                endcase
            end
        end
    end

    // Result for the tick being taken.
    always_comb
    begin
        result.ir_level = is_mark && cur_cl;
        result.busy     = active;
        result.done     = active && (cur_phase == PH_STOP_SPACE) && pt_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            phase_timer_reg   <= '0;
            carrier_timer_reg <= '0;
            carrier_level_reg <= 1'b0;
            shift_reg         <= '0;
            bits_left_reg     <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            phase_timer_reg   <= phase_timer_next;
            carrier_timer_reg <= carrier_timer_next;
            carrier_level_reg <= carrier_level_next;
            shift_reg         <= shift_next;
            bits_left_reg     <= bits_left_next;
        end
    end

    `ASSERT_CLK(a_phase_timer_live, (phase_reg != PH_IDLE) |-> (phase_timer_reg != '0), "phase timer is zero inside a frame")
    `ASSERT_CLK(a_carrier_timer_live, ((phase_reg == PH_LEAD_MARK) || (phase_reg == PH_BIT_MARK) || (phase_reg == PH_STOP_MARK)) |-> (carrier_timer_reg != '0), "carrier timer is zero during a mark")
    `ASSERT_NEXT(a_done_to_idle, accept && result.done, phase_reg == PH_IDLE, "frame did not return to idle after done")

endmodule

### hw/rtl/nec_irtx_outq.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nec_irtx_outq
    import nec_irtx_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t din,
    input  logic    out_stall,
    output logic    out_valid,
    output logic    full,
    output result_t dout
);

    logic [1:0] count_reg, count_next;
    logic [1:0] count_after_pop;
    result_t    entry0_reg, entry0_next;
    result_t    entry1_reg, entry1_next;
    logic       pop;

    assign pop       = (count_reg != 2'd0) && !out_stall;
    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign dout      = entry0_reg;

    always_comb
    begin
        entry0_next     = entry0_reg;
        entry1_next     = entry1_reg;
        count_after_pop = count_reg;
        if (pop)
        begin
            entry0_next     = entry1_reg;
            count_after_pop = count_reg - 2'd1;
        end
        count_next = count_after_pop;
        if (push)
        begin
            if (count_after_pop == 2'd0)
            begin
                entry0_next = din;
            end
            else
            begin
                entry1_next = din;
            end
            count_next = count_after_pop + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry0_reg <= entry0_next;
        entry1_reg <= entry1_next;
    end

    `ASSERT_CLK(a_count_range, count_reg != 2'd3, "output queue count out of range")
    `ASSERT_NEXT(a_full_holds, (count_reg == 2'd2) && out_stall, count_reg == 2'd2, "full output queue changed while stalled")

endmodule

### hw/rtl/nec_ir_frame_transmitter_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    start_req, payload, bit_count
// output    out        out_valid / out_stall  ir_level, busy_res, done_res
// config    in         cfg_we                 cfg_index, cfg_data
//
// One input word (one microsecond tick) is taken per clock cycle while in_stall
// is low; the frame state advances in a single combinational pass and the
// result word is registered in the output queue before it is offered.
// A two-entry output queue decouples the sides: input is stalled only when both
// entries hold words that the output side has not yet taken.
// Reset (rst_n low, asynchronous) empties the queue, idles the frame sequencer
// and loads the timing registers with their NEC defaults.

module nec_ir_frame_transmitter_unit
    import nec_irtx_pkg::*;
#(
    parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF,
    parameter int TIMER_WIDTH   = TIMER_WIDTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        start_req,
    input  logic [PAYLOAD_IN_WIDTH-1:0] payload,
    input  logic [BIT_COUNT_WIDTH-1:0]  bit_count,

    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        ir_level,
    output logic                        busy_res,
    output logic                        done_res,

    input  logic                        cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_WIDTH-1:0]        cfg_data
);

    cfg_t    cfg;
    result_t core_result;
    result_t out_result;
    logic    accept;
    logic    queue_full;

    // A tick is taken whenever the upstream side offers one and the queue has room.
    assign accept   = in_valid && !in_stall;
    assign in_stall = queue_full;

    nec_irtx_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Frame sequencer: leading mark and space, one mark and space per payload
    // bit, then the stop symbol. Carrier toggling happens only during marks.
    nec_irtx_core #(
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
        .TIMER_WIDTH   (TIMER_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .start_req (start_req),
        .payload   (payload),
        .bit_count (bit_count),
        .cfg       (cfg),
        .result    (core_result)
    );

    // Result register with a skid entry so a stalled output does not stop
    // the next tick from being taken.
    nec_irtx_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .din       (core_result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .full      (queue_full),
        .dout      (out_result)
    );

    assign ir_level = out_result.ir_level;
    assign busy_res = out_result.busy;
    assign done_res = out_result.done;

endmodule
